// File: hw/rtl/typed_box_overlap_sweep_assert.svh
// ---------------------------------------------------------------------------
// typed_box_overlap_sweep_assert.svh
// Assertion macros shared by the box overlap sweep RTL.
// ---------------------------------------------------------------------------
`ifndef TYPED_BOX_OVERLAP_SWEEP_ASSERT_SVH
`define TYPED_BOX_OVERLAP_SWEEP_ASSERT_SVH

// same-cycle implication, masked during reset
`define TBOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define TBOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tbos_pkg.sv
// ---------------------------------------------------------------------------
// tbos_pkg
// Types and constants of the typed box overlap sweep.
// ---------------------------------------------------------------------------
package tbos_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int SLOT_W    = 3;
    localparam int KIND_W    = 3;
    localparam int MASK_W    = 6;
    localparam int CFG_IDX_W = 3;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [MASK_W-1:0] t_mask;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    // box kinds
    localparam t_kind KIND_NONE     = 3'd0;
    localparam t_kind KIND_HITBOX   = 3'd1;
    localparam t_kind KIND_HURTBOX  = 3'd2;
    localparam t_kind KIND_PUSHBOX  = 3'd3;
    localparam t_kind KIND_SHOT     = 3'd4;
    localparam t_kind KIND_SHIELDED = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HURTBOX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIELDED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HITBOX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSHBOX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOT     = 3'd4;

    // mask reset values
    localparam t_mask HURTBOX_MASK_RST  = 6'd18;
    localparam t_mask SHIELDED_MASK_RST = 6'd2;
    localparam t_mask HITBOX_MASK_RST   = 6'd20;
    localparam t_mask PUSHBOX_MASK_RST  = 6'd8;
    localparam t_mask SHOT_MASK_RST     = 6'd4;

    typedef struct packed {
        logic               cmd;
        t_slot              slot;
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
        t_kind              kind;
        logic [7:0]         owner;
        logic               active;
        logic               valid_req;
    } t_req;

    typedef struct packed {
        logic  found;
        t_slot reacting_slot;
        t_slot other_slot;
        logic  last;
    } t_rsp;

    // geometry entry (62 bits)
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_box;

    // attribute entry (13 bits)
    typedef struct packed {
        t_kind      kind;
        logic [7:0] owner;
        logic       active;
        logic       valid;
    } t_attr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/tbos_req_if.sv
// ---------------------------------------------------------------------------
// tbos_req_if
// Command channel: valid/ready handshake with a request beat.
// ---------------------------------------------------------------------------
interface tbos_req_if;
    logic            valid;
    logic            ready;
    tbos_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/tbos_rsp_if.sv
// ---------------------------------------------------------------------------
// tbos_rsp_if
// Result channel: valid/ready handshake with a result beat.
// ---------------------------------------------------------------------------
interface tbos_rsp_if;
    logic            valid;
    logic            ready;
    tbos_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/tbos_ram.sv
// ---------------------------------------------------------------------------
// tbos_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module tbos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: hw/rtl/typed_box_overlap_sweep.sv
// ---------------------------------------------------------------------------
// typed_box_overlap_sweep
// Table of typed axis-aligned boxes with a pairwise overlap sweep.
// ---------------------------------------------------------------------------
// A write beat (cmd=0) stores one slot and gives no result; writes to a
// slot at or above SLOTS are dropped. A sweep beat (cmd=1) walks all slot
// pairs i<j, i outer, j inner. Geometry and attributes sit in two small
// RAMs with two read ports, so each pair goes through a read step and an
// evaluate step, and each reaction found goes through an emit step to be
// queued. A sweep walks SLOTS*(SLOTS-1)/2 pairs and can stall while the
// result side holds ready low. Results are sent in pair order, (i,j) before
// (j,i); the last one carries last=1, and a sweep that finds nothing sends a
// single beat with found=0. The newest result is held back in a pending
// register until the next result or the end of the sweep, so its last flag
// is known before it goes out. The command side takes a new beat as soon as
// the previous one is finished, even while the final result still waits in
// the output register. The user must write the mask registers through the
// config port only while the block is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
module typed_box_overlap_sweep #(
    parameter int SLOTS = tbos_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tbos_req_if.sink                         i_req,
    tbos_rsp_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [tbos_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tbos_pkg::MASK_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_J = AW'(SLOTS - 1);
    localparam logic [AW-1:0] LAST_I = AW'(SLOTS - 2);

    // reaction mask for a kind; none and unused kinds react to nothing
    function automatic tbos_pkg::t_mask mask_of(
        input tbos_pkg::t_kind kind,
        input tbos_pkg::t_mask m_hit,
        input tbos_pkg::t_mask m_hurt,
        input tbos_pkg::t_mask m_push,
        input tbos_pkg::t_mask m_shot,
        input tbos_pkg::t_mask m_shield
    );
        tbos_pkg::t_mask m;
        unique case (kind)
            tbos_pkg::KIND_HITBOX:   m = m_hit;
            tbos_pkg::KIND_HURTBOX:  m = m_hurt;
            tbos_pkg::KIND_PUSHBOX:  m = m_push;
            tbos_pkg::KIND_SHOT:     m = m_shot;
            tbos_pkg::KIND_SHIELDED: m = m_shield;
            default:                 m = '0;
        endcase
        return m;
    endfunction

    function automatic logic mask_hit(input tbos_pkg::t_mask m,
                                      input tbos_pkg::t_kind k);
        logic hit;
        hit = 1'b0;
        if (k <= tbos_pkg::KIND_SHIELDED) begin
            hit = m[k];
        end
        return hit;
    endfunction

    // strict overlap; 17-bit signed edges so sums never wrap
    function automatic logic overlap(input tbos_pkg::t_box a,
                                     input tbos_pkg::t_box b);
        logic signed [16:0] ax, ay, bx, by, ax2, ay2, bx2, by2;
        ax  = 17'(a.x);
        ay  = 17'(a.y);
        bx  = 17'(b.x);
        by  = 17'(b.y);
        ax2 = ax + $signed({2'b00, a.w});
        ay2 = ay + $signed({2'b00, a.h});
        bx2 = bx + $signed({2'b00, b.w});
        by2 = by + $signed({2'b00, b.h});
        return (by2 > ay) && (by < ay2) && (bx2 > ax) && (bx < ax2);
    endfunction

    // control state
    tbos_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             r_pend_v, n_pend_v;
    logic [SLOTS-1:0] r_written, n_written;
    tbos_pkg::t_mask  r_m_hurt, r_m_shield, r_m_hit, r_m_push, r_m_shot;

    // datapath
    logic [AW-1:0]    r_i, n_i;
    logic [AW-1:0]    r_j, n_j;
    logic             r_phase, n_phase;
    logic             r_hit_ij, n_hit_ij;
    logic             r_hit_ji, n_hit_ji;
    tbos_pkg::t_slot  r_pend_r, n_pend_r;
    tbos_pkg::t_slot  r_pend_o, n_pend_o;
    tbos_pkg::t_rsp   r_out, n_out;

    // RAM side
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    tbos_pkg::t_box   box_wdata, box_a, box_b;
    tbos_pkg::t_attr  attr_wdata, attr_a, attr_b;

    logic             in_acc;
    logic             out_free;
    logic             pair_ok;
    logic             cand_hit_ij, cand_hit_ji;

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready   = (r_state == tbos_pkg::ST_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    assign ram_waddr = i_req.payload.slot[AW-1:0];
    assign box_wdata = '{x: i_req.payload.left_x, y: i_req.payload.top_y,
                         w: i_req.payload.box_w,  h: i_req.payload.box_h};
    assign attr_wdata = '{kind:   i_req.payload.kind,
                          owner:  i_req.payload.owner,
                          active: i_req.payload.active,
                          valid:  i_req.payload.valid_req};

    tbos_ram #(
        .WIDTH ($bits(tbos_pkg::t_box)),
        .DEPTH (SLOTS)
    ) u_box_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (box_wdata),
        .i_raddr_a (r_i),
        .i_raddr_b (r_j),
        .o_rdata_a (box_a),
        .o_rdata_b (box_b)
    );

    tbos_ram #(
        .WIDTH ($bits(tbos_pkg::t_attr)),
        .DEPTH (SLOTS)
    ) u_attr_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (attr_wdata),
        .i_raddr_a (r_i),
        .i_raddr_b (r_j),
        .o_rdata_a (attr_a),
        .o_rdata_b (attr_b)
    );

    // pair qualification on the RAM read data; unwritten slots count as empty
    always_comb begin
        pair_ok = r_written[r_i] && r_written[r_j]
                  && attr_a.valid && attr_b.valid
                  && attr_a.active && attr_b.active
                  && (attr_a.owner != attr_b.owner)
                  && overlap(box_a, box_b);
        cand_hit_ij = pair_ok && mask_hit(
            mask_of(attr_a.kind, r_m_hit, r_m_hurt, r_m_push, r_m_shot, r_m_shield),
            attr_b.kind);
        cand_hit_ji = pair_ok && mask_hit(
            mask_of(attr_b.kind, r_m_hit, r_m_hurt, r_m_push, r_m_shot, r_m_shield),
            attr_a.kind);
    end

    // next state and outputs
    always_comb begin
        logic advance;
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        n_pend_v    = r_pend_v;
        n_pend_r    = r_pend_r;
        n_pend_o    = r_pend_o;
        n_written   = r_written;
        n_i         = r_i;
        n_j         = r_j;
        n_phase     = r_phase;
        n_hit_ij    = r_hit_ij;
        n_hit_ji    = r_hit_ji;
        ram_we      = 1'b0;
        advance     = 1'b0;

        unique case (r_state)
            tbos_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req.payload.cmd == tbos_pkg::CMD_SWEEP) begin
                        n_i      = '0;
                        n_j      = AW'(1);
                        n_pend_v = 1'b0;
                        n_state  = tbos_pkg::ST_READ;
                    end else if (int'(i_req.payload.slot) < SLOTS) begin
                        ram_we               = 1'b1;
                        n_written[ram_waddr] = 1'b1;
                    end
                end
            end
            tbos_pkg::ST_READ: begin
                n_state = tbos_pkg::ST_EVAL;
            end
            tbos_pkg::ST_EVAL: begin
                n_hit_ij = cand_hit_ij;
                n_hit_ji = cand_hit_ji;
                n_phase  = !cand_hit_ij;
                if (cand_hit_ij || cand_hit_ji) begin
                    n_state = tbos_pkg::ST_EMIT;
                end else begin
                    advance = 1'b1;
                end
            end
            tbos_pkg::ST_EMIT: begin
                // hold the new hit; flush the older one when the output frees
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_valid = 1'b1;
                        n_out       = '{found: 1'b1, reacting_slot: r_pend_r,
                                        other_slot: r_pend_o, last: 1'b0};
                    end
                    n_pend_v = 1'b1;
                    n_pend_r = r_phase ? tbos_pkg::t_slot'(r_j) : tbos_pkg::t_slot'(r_i);
                    n_pend_o = r_phase ? tbos_pkg::t_slot'(r_i) : tbos_pkg::t_slot'(r_j);
                    if (!r_phase && r_hit_ji) begin
                        n_phase = 1'b1;
                    end else begin
                        advance = 1'b1;
                    end
                end
            end
            tbos_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_v) begin
                        n_out = '{found: 1'b1, reacting_slot: r_pend_r,
                                  other_slot: r_pend_o, last: 1'b1};
                    end else begin
                        n_out = '{found: 1'b0, reacting_slot: '0,
                                  other_slot: '0, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = tbos_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbos_pkg::ST_IDLE;
            end
        endcase

        // step to the next pair in i-outer, j-inner order
        if (advance) begin
            if (r_j == LAST_J) begin
                if (r_i == LAST_I) begin
                    n_state = tbos_pkg::ST_DONE;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_j     = r_i + AW'(2);
                    n_state = tbos_pkg::ST_READ;
                end
            end else begin
                n_j     = r_j + AW'(1);
                n_state = tbos_pkg::ST_READ;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbos_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
            r_written   <= '0;
            r_m_hurt    <= tbos_pkg::HURTBOX_MASK_RST;
            r_m_shield  <= tbos_pkg::SHIELDED_MASK_RST;
            r_m_hit     <= tbos_pkg::HITBOX_MASK_RST;
            r_m_push    <= tbos_pkg::PUSHBOX_MASK_RST;
            r_m_shot    <= tbos_pkg::SHOT_MASK_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend_v    <= n_pend_v;
            r_written   <= n_written;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tbos_pkg::CFG_HURTBOX:  r_m_hurt   <= i_cfg_data;
                    tbos_pkg::CFG_SHIELDED: r_m_shield <= i_cfg_data;
                    tbos_pkg::CFG_HITBOX:   r_m_hit    <= i_cfg_data;
                    tbos_pkg::CFG_PUSHBOX:  r_m_push   <= i_cfg_data;
                    tbos_pkg::CFG_SHOT:     r_m_shot   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_phase  <= n_phase;
        r_hit_ij <= n_hit_ij;
        r_hit_ji <= n_hit_ji;
        r_pend_r <= n_pend_r;
        r_pend_o <= n_pend_o;
        r_out    <= n_out;
    end

`include "typed_box_overlap_sweep_assert.svh"

    `TBOS_ASSERT_NEXT(a_sweep_starts_read, i_clk, i_rst_n, in_acc && (i_req.payload.cmd == tbos_pkg::CMD_SWEEP), r_state == tbos_pkg::ST_READ, "sweep beat did not start a pair read")
    `TBOS_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, (r_state == tbos_pkg::ST_READ) || (r_state == tbos_pkg::ST_EVAL) || (r_state == tbos_pkg::ST_EMIT), r_i < r_j, "pair counters out of order")
    `TBOS_ASSERT_NOW(a_emit_has_hit, i_clk, i_rst_n, r_state == tbos_pkg::ST_EMIT, r_phase ? r_hit_ji : r_hit_ij, "emit step without a reaction")
    `TBOS_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, r_out_valid && !r_out.found, r_out.last && (r_out.reacting_slot == '0) && (r_out.other_slot == '0), "empty sweep beat malformed")
    `TBOS_ASSERT_NOW(a_found_distinct, i_clk, i_rst_n, r_out_valid && r_out.found, r_out.reacting_slot != r_out.other_slot, "reaction pairs a slot with itself")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed box overlap sweep.
// ---------------------------------------------------------------------------
// Drives write and sweep beats into the command channel and keeps a shadow
// copy of the box table and the five reaction masks. On every accepted sweep
// the shadow walks the slot pairs and queues the result beats it expects.
// A monitor on the result channel compares each beat, field by field, with
// the oldest expected one. Directed phases cover the empty table, every kind
// pair, edge geometry and the mask extremes. A random phase follows with
// write bursts and sweeps, reprogrammed masks, sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_top;
    import tbos_pkg::*;

    localparam int SLOTS         = SLOTS_DEF;
    localparam int RANDOM_ITEMS  = 110;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;  // cycles to wait for results to drain

    // indexes past the end of the register list: writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam t_mask MASK_ALL  = '1;
    localparam t_mask MASK_NONE = '0;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_BURSTY
    } t_rdy_pattern;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_mask                i_cfg_data;

    tbos_req_if req_if ();
    tbos_rsp_if rsp_if ();

    typed_box_overlap_sweep #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // shadow of the block state
    // -----------------------------------------------------------------------
    int         geo_x       [SLOTS];
    int         geo_y       [SLOTS];
    int         geo_w       [SLOTS];
    int         geo_h       [SLOTS];
    t_kind      slot_kind   [SLOTS];
    logic [7:0] slot_owner  [SLOTS];
    bit         slot_active [SLOTS];
    bit         slot_valid  [SLOTS];   // all slots empty after reset
    t_mask      mask_reg    [5];

    t_rsp pending_hits [$];            // result beats still owed by the block

    int err_count     = 0;
    int n_writes      = 0;
    int n_sweeps      = 0;
    int n_beats       = 0;
    int n_pairs       = 0;
    int n_mask_writes = 0;

    // idling knobs, changed per phase
    int           gap_max    = 0;
    int           burst_left = 0;
    int           stall_left = 0;
    t_rdy_pattern rdy_mode   = RDY_ALWAYS;

    // -----------------------------------------------------------------------
    // clock and timeout
    // -----------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // prediction
    // -----------------------------------------------------------------------
    // which register holds the mask of a kind; none and the unused kinds
    // react to nothing
    function automatic t_mask mask_of_kind(input t_kind k);
        case (k)
            KIND_HITBOX:   return mask_reg[CFG_HITBOX];
            KIND_HURTBOX:  return mask_reg[CFG_HURTBOX];
            KIND_PUSHBOX:  return mask_reg[CFG_PUSHBOX];
            KIND_SHOT:     return mask_reg[CFG_SHOT];
            KIND_SHIELDED: return mask_reg[CFG_SHIELDED];
            default:       return MASK_NONE;
        endcase
    endfunction

    function automatic bit kind_reacts(input t_kind who, input t_kind touched);
        t_mask m;
        m = mask_of_kind(who);
        // no mask bit exists for kinds past shielded
        if (touched > KIND_SHIELDED) return 1'b0;
        return m[touched];
    endfunction

    // strict overlap: shared edges never count
    function automatic bit boxes_overlap(input int a, input int b);
        return (geo_y[b] + geo_h[b] > geo_y[a]) && (geo_y[b] < geo_y[a] + geo_h[a]) &&
               (geo_x[b] + geo_w[b] > geo_x[a]) && (geo_x[b] < geo_x[a] + geo_w[a]);
    endfunction

    function automatic t_rsp hit_of(input int r, input int o);
        t_rsp h;
        h.found         = 1'b1;
        h.reacting_slot = t_slot'(r);
        h.other_slot    = t_slot'(o);
        h.last          = 1'b0;
        return h;
    endfunction

    // pair walk, i outer and j inner; (i,j) goes before (j,i)
    function automatic void sweep_pairs();
        t_rsp hits [$];
        t_rsp none_hit;
        for (int i = 0; i < SLOTS; i++) begin
            for (int j = i + 1; j < SLOTS; j++) begin
                if (!(slot_valid[i] && slot_valid[j] && slot_active[i] && slot_active[j]))
                    continue;
                if (!boxes_overlap(i, j) || slot_owner[i] == slot_owner[j])
                    continue;
                if (kind_reacts(slot_kind[i], slot_kind[j])) hits = {hits, hit_of(i, j)};
                if (kind_reacts(slot_kind[j], slot_kind[i])) hits = {hits, hit_of(j, i)};
            end
        end
        if (hits.size() == 0) begin
            none_hit = '0;
            none_hit.last = 1'b1;
            hits = {hits, none_hit};
        end else begin
            n_pairs += hits.size();
            hits[hits.size() - 1].last = 1'b1;
        end
        pending_hits = {pending_hits, hits};
    endfunction

    // update the shadow for one accepted beat
    function automatic void track_beat(input t_req r);
        int s;
        if (r.cmd == CMD_WRITE) begin
            n_writes++;
            s = int'(r.slot);
            if (s < SLOTS) begin
                // fields are stored even when the slot is being emptied
                geo_x[s]       = r.left_x;
                geo_y[s]       = r.top_y;
                geo_w[s]       = r.box_w;
                geo_h[s]       = r.box_h;
                slot_kind[s]   = r.kind;
                slot_owner[s]  = r.owner;
                slot_active[s] = r.active;
                slot_valid[s]  = r.valid_req;
            end
        end else begin
            n_sweeps++;
            sweep_pairs();
        end
    endfunction

    // -----------------------------------------------------------------------
    // result monitor
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : check_result
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            n_beats++;
            if (pending_hits.size() == 0) begin
                $error("unexpected result beat: found=%0d reacting=%0d other=%0d last=%0d",
                       got.found, got.reacting_slot, got.other_slot, got.last);
                err_count++;
            end else begin
                want = pending_hits.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    err_count++;
                end
                if (got.reacting_slot !== want.reacting_slot) begin
                    $error("reacting_slot: expected %0d, got %0d",
                           want.reacting_slot, got.reacting_slot);
                    err_count++;
                end
                if (got.other_slot !== want.other_slot) begin
                    $error("other_slot: expected %0d, got %0d",
                           want.other_slot, got.other_slot);
                    err_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    err_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // receiver: ready follows the pattern of the current phase
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        case (rdy_mode)
            RDY_ALWAYS: begin
                rsp_if.ready = 1'b1;
            end
            RDY_RANDOM: begin
                rsp_if.ready = ($urandom_range(0, 3) != 0);
            end
            default: begin
                // long stalls now and then, open otherwise
                if (stall_left > 0) begin
                    stall_left--;
                    rsp_if.ready = 1'b0;
                end else if ($urandom_range(0, 4) == 0) begin
                    stall_left   = $urandom_range(1, 12);
                    rsp_if.ready = 1'b0;
                end else begin
                    rsp_if.ready = 1'b1;
                end
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // sender and config port
    // -----------------------------------------------------------------------
    // one command beat; bursts of random length with random gaps between
    task automatic send_beat(input t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                req_if.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid   = 1'b1;
        req_if.payload = r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        track_beat(r);
    endtask

    // drop valid, let every owed result arrive, then let the block settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_hits.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_hits.size() != 0) begin
            $error("%0d result beats never arrived", pending_hits.size());
            err_count++;
            pending_hits.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // masks change only while nothing is in flight
    task automatic write_mask(input int idx, input t_mask val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_IDX_W'(idx);
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        n_mask_writes++;
        if (idx <= int'(CFG_SHOT)) mask_reg[idx] = val;
    endtask

    // -----------------------------------------------------------------------
    // beat builders
    // -----------------------------------------------------------------------
    function automatic t_req box_beat(input int s, input int x, input int y,
                                      input int w, input int h, input t_kind k,
                                      input int own, input bit act, input bit vld);
        t_req r;
        r           = '0;
        r.cmd       = CMD_WRITE;
        r.slot      = t_slot'(s);
        r.left_x    = 16'(x);
        r.top_y     = 16'(y);
        r.box_w     = 15'(w);
        r.box_h     = 15'(h);
        r.kind      = k;
        r.owner     = 8'(own);
        r.active    = act;
        r.valid_req = vld;
        return r;
    endfunction

    // sweep with junk in the unused fields
    function automatic t_req sweep_beat();
        t_req        r;
        logic [95:0] raw;
        raw   = {$urandom(), $urandom(), $urandom()};
        r     = raw[$bits(t_req)-1:0];
        r.cmd = CMD_SWEEP;
        return r;
    endfunction

    // random write: mostly small boxes near the origin so overlaps are
    // common, sometimes the full coordinate range
    function automatic t_req rand_write();
        t_req        r;
        logic [95:0] raw;
        raw   = {$urandom(), $urandom(), $urandom()};
        r     = raw[$bits(t_req)-1:0];
        r.cmd = CMD_WRITE;
        if ($urandom_range(0, 99) < 85) begin
            r.left_x = 16'($urandom_range(0, 160) - 80);
            r.top_y  = 16'($urandom_range(0, 160) - 80);
            r.box_w  = 15'($urandom_range(0, 90));
            r.box_h  = 15'($urandom_range(0, 90));
        end
        if ($urandom_range(0, 9) < 8)
            r.kind = t_kind'($urandom_range(KIND_HITBOX, KIND_SHIELDED));
        if ($urandom_range(0, 9) < 7)
            r.owner = 8'($urandom_range(0, 3));   // few owners: many shared
        r.active    = ($urandom_range(0, 9) != 0);
        r.valid_req = ($urandom_range(0, 9) != 0);
        return r;
    endfunction

    // all kinds stacked on one spot, distinct owners
    task automatic fill_kind_ladder();
        for (int s = 0; s < SLOTS; s++)
            send_beat(box_beat(s, 0, 0, 100, 100, t_kind'(s), s + 1, 1'b1, 1'b1));
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    // fresh table: a sweep must report nothing found
    task automatic test_empty_table();
        gap_max  = 0;
        rdy_mode = RDY_ALWAYS;
        send_beat(sweep_beat());
    endtask

    // every kind against every other with the reset masks, kinds past
    // shielded included
    task automatic test_kind_matrix();
        gap_max  = 0;
        rdy_mode = RDY_RANDOM;
        fill_kind_ladder();
        send_beat(sweep_beat());
    endtask

    // coordinate extremes, shared edges, empty box, inactive box, same owner,
    // then a slot emptied
    task automatic test_geometry_edges();
        gap_max  = 3;
        rdy_mode = RDY_RANDOM;
        // most negative corner, right/bottom edge at -1
        send_beat(box_beat(0, -32768, -32768, 32767, 32767, KIND_HITBOX, 10, 1'b1, 1'b1));
        // corner touches slot 0 and slot 2: no overlap
        send_beat(box_beat(1, -1, -1, 5, 5, KIND_HURTBOX, 11, 1'b1, 1'b1));
        send_beat(box_beat(2, -2, -2, 1, 1, KIND_HURTBOX, 12, 1'b1, 1'b1));
        // most positive corner with the widest box
        send_beat(box_beat(3, 32767, 32767, 32767, 32767, KIND_HURTBOX, 13, 1'b1, 1'b1));
        send_beat(box_beat(4, 32766, 32766, 2, 2, KIND_HITBOX, 14, 1'b1, 1'b1));
        // inactive box over slot 4
        send_beat(box_beat(5, 32766, 32766, 4, 4, KIND_HURTBOX, 17, 1'b0, 1'b1));
        // zero width inside slot 4's area
        send_beat(box_beat(6, 32767, 32767, 0, 10, KIND_HURTBOX, 18, 1'b1, 1'b1));
        // same owner as slot 3
        send_beat(box_beat(7, 32760, 32760, 20, 20, KIND_SHOT, 13, 1'b1, 1'b1));
        send_beat(sweep_beat());
        // empty slot 4 (fields still stored)
        send_beat(box_beat(4, 32766, 32766, 2, 2, KIND_HITBOX, 14, 1'b1, 1'b0));
        send_beat(sweep_beat());
    endtask

    // all masks full, all empty, and writes past the register list
    task automatic test_mask_extremes();
        gap_max  = 4;
        rdy_mode = RDY_BURSTY;
        for (int k = CFG_HURTBOX; k <= CFG_SHOT; k++) write_mask(k, MASK_ALL);
        // bit 0 set: kind none is now touched
        fill_kind_ladder();
        send_beat(sweep_beat());
        // eight hurtboxes on one spot: every ordered pair reacts
        for (int s = 0; s < SLOTS; s++)
            send_beat(box_beat(s, -5, -5, 10, 10, KIND_HURTBOX, 100 + s, 1'b1, 1'b1));
        send_beat(sweep_beat());
        for (int k = CFG_HURTBOX; k <= CFG_SHOT; k++) write_mask(k, MASK_NONE);
        send_beat(sweep_beat());
        for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) write_mask(k, MASK_ALL);
        send_beat(sweep_beat());
    endtask

    // rounds of a few writes and a sweep; some rounds skip the write or the
    // sweep; masks and idling change between rounds
    task automatic test_random_traffic();
        int    sent;
        int    nwr;
        t_mask m;
        sent = 0;
        for (int k = CFG_HURTBOX; k <= CFG_SHOT; k++) write_mask(k, t_mask'($urandom()));
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 6;
            endcase
            rdy_mode = t_rdy_pattern'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) begin
                for (int k = CFG_HURTBOX; k <= CFG_SHOT; k++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        case ($urandom_range(0, 5))
                            0:       m = MASK_NONE;
                            1:       m = MASK_ALL;
                            default: m = t_mask'($urandom());
                        endcase
                        write_mask(k, m);
                    end
                end
            end
            nwr = $urandom_range(0, 6);
            repeat (nwr) begin
                send_beat(rand_write());
                sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
                send_beat(sweep_beat());
                sent++;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;

        mask_reg[CFG_HURTBOX]  = HURTBOX_MASK_RST;
        mask_reg[CFG_SHIELDED] = SHIELDED_MASK_RST;
        mask_reg[CFG_HITBOX]   = HITBOX_MASK_RST;
        mask_reg[CFG_PUSHBOX]  = PUSHBOX_MASK_RST;
        mask_reg[CFG_SHOT]     = SHOT_MASK_RST;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_kind_matrix();
        test_geometry_edges();
        test_mask_extremes();
        test_random_traffic();
        wait_idle();

        $display("covered %0d slot writes and %0d sweeps, %0d result beats checked",
                 n_writes, n_sweeps, n_beats);
        $display("%0d reaction pairs predicted over %0d mask register writes",
                 n_pairs, n_mask_writes);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
